// ===== rtl/ots_pkg.sv =====
// ----------------------------------------------------------------------------
// ots_pkg: shared types, tables and command encoding
// Band tables, register map, command codes and the command-step function
// used by the tuning-word sequencer front end and command back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ots_pkg;

	// Command kinds on the oscillator bus
	localparam logic [1:0] OP_WR  = 2'd0;
	localparam logic [1:0] OP_OR  = 2'd1;
	localparam logic [1:0] OP_AND = 2'd2;

	// Oscillator register map
	localparam logic [7:0] REG_HS    = 8'd13;
	localparam logic [7:0] REG_N1    = 8'd14;
	localparam logic [7:0] REG_RF3   = 8'd15;
	localparam logic [7:0] REG_RF2   = 8'd16;
	localparam logic [7:0] REG_RF1   = 8'd17;
	localparam logic [7:0] REG_RF0   = 8'd18;
	localparam logic [7:0] REG_CTRL  = 8'd135;
	localparam logic [7:0] REG_DCO   = 8'd137;

	// Control values
	localparam logic [7:0] DCO_FREEZE   = 8'h10;
	localparam logic [7:0] DCO_UNFREEZE = 8'hEF;
	localparam logic [7:0] CTRL_NEWFREQ = 8'h40;
	localparam logic [7:0] CTRL_FREEZEM = 8'h20;
	localparam logic [7:0] CTRL_RUN     = 8'h00;

	// Band select reset value: no band loaded
	localparam logic [3:0] BAND_NONE = 4'd15;

	// Command steps: band change steps first, then the tuning update
	localparam logic [3:0] ST_FREEZE    = 4'd0;
	localparam logic [3:0] ST_HS        = 4'd1;
	localparam logic [3:0] ST_N1        = 4'd2;
	localparam logic [3:0] ST_C3        = 4'd3;
	localparam logic [3:0] ST_C2        = 4'd4;
	localparam logic [3:0] ST_C1        = 4'd5;
	localparam logic [3:0] ST_C0        = 4'd6;
	localparam logic [3:0] ST_UNFREEZE  = 4'd7;
	localparam logic [3:0] ST_NEWFREQ   = 4'd8;
	localparam logic [3:0] ST_TUNE_OPEN = 4'd9;
	localparam logic [3:0] ST_W3        = 4'd10;
	localparam logic [3:0] ST_W2        = 4'd11;
	localparam logic [3:0] ST_W1        = 4'd12;
	localparam logic [3:0] ST_W0        = 4'd13;
	localparam logic [3:0] ST_TUNE_DONE = 4'd14;

	// Queue between front end and back end
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Exact divide by 1000 for values below 2**25: (x * DIV1K_MUL) >> DIV1K_SHIFT
	localparam logic [25:0] DIV1K_MUL   = 26'd34359739;
	localparam int          DIV1K_SHIFT = 35;

	// Band tables; rows past the defined bands are zero
	localparam logic [7:0] CEN_B13 [16] = '{8'hA1, 8'hA1, 8'hE1, 8'hE1, 8'hE1, 8'h61, 8'hA1,
		8'hA1, 8'hA1, 8'hA1, 8'hA1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] CEN_B14 [16] = '{8'hC2, 8'hC2, 8'h42, 8'h42, 8'h43, 8'hC2, 8'h42,
		8'h42, 8'h42, 8'h42, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] CEN_B15 [16] = '{8'hD9, 8'hEC, 8'hCD, 8'hE8, 8'h0D, 8'hB6, 8'hB5,
		8'hD1, 8'hEA, 8'hEE, 8'hF2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] CEN_B16 [16] = '{8'h80, 8'h27, 8'h3B, 8'hBA, 8'hED, 8'h91, 8'h42,
		8'h59, 8'h60, 8'h37, 8'hC1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] CEN_B17 [16] = '{8'hF0, 8'hE8, 8'h91, 8'h58, 8'h66, 8'hD6, 8'h02,
		8'h80, 8'hFF, 8'hAE, 8'h29, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] CEN_B18 [16] = '{8'h65, 8'hA7, 8'h73, 8'hC7, 8'h75, 8'h25, 8'hE5,
		8'hC0, 8'h03, 8'h98, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

	localparam logic [31:0] CENTRE_WORD [16] = '{32'hD980F058, 32'hEC27E89A, 32'hCD3B9167,
		32'hE8BA58BA, 32'h0E288CA7, 32'hB691D619, 32'hB54202D9, 32'hD15980B4, 32'hEA60FEF6,
		32'hEE37AE8C, 32'hF2C12934, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};

	localparam logic [24:0] CENTRE_HZ [16] = '{25'd1900000, 25'd3750000, 25'd7150000,
		25'd10125000, 25'd14175000, 25'd18118000, 25'd21225000, 25'd24940000, 25'd28250000,
		25'd28757640, 25'd29357640, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0};

	localparam logic [17:0] STEP_K [16] = '{18'h2949B, 18'h25D8E, 18'h25D8E, 18'h25D8E,
		18'h25D8E, 18'h201CE, 18'h1EF74, 18'h1EF74, 18'h1EF74, 18'h1EF74, 18'h1EF74,
		18'h0, 18'h0, 18'h0, 18'h0, 18'h0};
	localparam logic [14:0] STEP_H [16] = '{15'h4213, 15'h4213, 15'h3C91, 15'h3C91,
		15'h3C91, 15'h3364, 15'h318E, 15'h318E, 15'h318E, 15'h318E, 15'h318E,
		15'h0, 15'h0, 15'h0, 15'h0, 15'h0};
	localparam logic [10:0] STEP_T [16] = '{11'h69B, 11'h69B, 11'h60E, 11'h60E, 11'h60E,
		11'h523, 11'h4F4, 11'h4F4, 11'h4F4, 11'h4F4, 11'h4F4,
		11'h0, 11'h0, 11'h0, 11'h0, 11'h0};

	// Calibration offset in Hz, two's complement
	localparam logic [7:0] CAL_HZ [16] = '{8'sd0, 8'sd0, 8'sd0, 8'sd20, -8'sd70, 8'sd0,
		8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0};

	// Per-request job handed from front end to back end
	typedef struct packed {
		logic        chg;
		logic [3:0]  band;
		logic [31:0] word;
	} ots_item_t;

	// Sideband that travels down the front-end pipeline
	typedef struct packed {
		logic       chg;
		logic       below;
		logic [3:0] band;
	} ots_tag_t;

	// One register command
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] reg_addr;
		logic [7:0] data;
		logic       last;
	} ots_cmd_t;

	// Build the command for one step of a job
	function automatic ots_cmd_t ots_command(input logic [3:0] step, input ots_item_t item);
		ots_cmd_t c;
		c.op       = OP_WR;
		c.reg_addr = REG_CTRL;
		c.data     = CTRL_RUN;
		c.last     = 1'b0;
		unique case (step)
			ST_FREEZE: begin
				c.op       = OP_OR;
				c.reg_addr = REG_DCO;
				c.data     = DCO_FREEZE;
			end
			ST_HS: begin
				c.reg_addr = REG_HS;
				c.data     = CEN_B13[item.band];
			end
			ST_N1: begin
				c.reg_addr = REG_N1;
				c.data     = CEN_B14[item.band];
			end
			ST_C3: begin
				c.reg_addr = REG_RF3;
				c.data     = CEN_B15[item.band];
			end
			ST_C2: begin
				c.reg_addr = REG_RF2;
				c.data     = CEN_B16[item.band];
			end
			ST_C1: begin
				c.reg_addr = REG_RF1;
				c.data     = CEN_B17[item.band];
			end
			ST_C0: begin
				c.reg_addr = REG_RF0;
				c.data     = CEN_B18[item.band];
			end
			ST_UNFREEZE: begin
				c.op       = OP_AND;
				c.reg_addr = REG_DCO;
				c.data     = DCO_UNFREEZE;
			end
			ST_NEWFREQ: begin
				c.data = CTRL_NEWFREQ;
			end
			ST_TUNE_OPEN: begin
				c.data = CTRL_FREEZEM;
			end
			ST_W3: begin
				c.reg_addr = REG_RF3;
				c.data     = item.word[31:24];
			end
			ST_W2: begin
				c.reg_addr = REG_RF2;
				c.data     = item.word[23:16];
			end
			ST_W1: begin
				c.reg_addr = REG_RF1;
				c.data     = item.word[15:8];
			end
			ST_W0: begin
				c.reg_addr = REG_RF0;
				c.data     = item.word[7:0];
			end
			ST_TUNE_DONE: begin
				c.last = 1'b1;
			end
			default: begin
				c.last = 1'b0;
			end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/oscillator_tuning_word_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// oscillator_tuning_word_sequencer_top: oscillator tuning command generator
// Turns frequency requests into oscillator register command words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one request per word, s_tdata holds the frequency in Hz,
//   s_tuser the band index. Requests for bands at or above NUM_BANDS are
//   taken and dropped without output.
//   Master channel: one register command per word; m_tlast marks the final
//   command of a request. A request gives 6 commands, or 15 when its band
//   differs from the band loaded last.
//   Path: a request's first command reaches the master port through
//   the 9-stage tuning word pipeline, the queue write and the command
//   register. Throughput: the intake takes a request every cycle while
//   the 4-entry job queue has room; the sustained rate is one command per
//   cycle at the master port while m_tready is high and a job is queued.
//   Reset: clears the pipeline, the queue and the output, and marks no band
//   as loaded, so the first request runs the band change sequence.
//   Stall: when m_tready is low the command word holds; the queue fills,
//   then the pipeline halts and s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module oscillator_tuning_word_sequencer_top
	import ots_pkg::*;
#(
	parameter int NUM_BANDS = 11
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [24:0] freq_hz, rest zero
	input  wire logic [3:0]  s_tuser,   // [3:0] band
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] reg_addr, [15:8] data
	output logic [1:0]       m_tuser,   // [1:0] op
	output logic             m_tlast
);

	logic      q_ready;
	logic      push;
	ots_item_t push_item;
	logic      q_valid;
	logic      pop;
	ots_item_t head;
	ots_cmd_t  cmd;

	ots_front #(
		.NUM_BANDS(NUM_BANDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.freq_hz  (s_tdata[24:0]),
		.band     (s_tuser),
		.q_ready  (q_ready),
		.push     (push),
		.push_item(push_item)
	);

	ots_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.ready    (q_ready),
		.pop      (pop),
		.valid    (q_valid),
		.head     (head)
	);

	ots_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_cmd  (cmd)
	);

	// Pack the command word
	assign m_tdata = {cmd.data, cmd.reg_addr};
	assign m_tuser = cmd.op;
	assign m_tlast = cmd.last;

endmodule

`default_nettype wire

// ===== rtl/ots_front.sv =====
// ----------------------------------------------------------------------------
// ots_front: request intake and tuning word pipeline
// Accepts requests, drops out-of-range bands, flags band changes, and
// computes the 32-bit tuning word in a nine-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ots_front
	import ots_pkg::*;
#(
	parameter int NUM_BANDS = 11
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [24:0] freq_hz,
	input  wire logic [3:0]  band,
	input  wire logic        q_ready,
	output logic             push,
	output ots_item_t        push_item
);

	localparam int         NUM_STAGES = 9;
	localparam logic [4:0] BAND_LIMIT = 5'(NUM_BANDS);

	logic [NUM_STAGES-1:0] stage_vld_q;
	logic [3:0]            cur_band_q;
	logic                  adv;
	logic                  band_ok;

	logic [24:0] freq_s1;
	ots_tag_t    tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8, tag_s9;
	logic [24:0] dist_s2, dist_s3;
	logic [15:0] th_s3;
	logic [9:0]  rem_s4, rem_s5;
	logic [31:0] pk_s4, pk_s5, pk_s6, pk_s7;
	logic [3:0]  hu_s5;
	logic [6:0]  r2_s6;
	logic [31:0] ph_s6, ph_s7;
	logic [3:0]  te_s7;
	logic [31:0] pt_s8, suma_s8, sum_s9;

	logic [26:0] diff;
	logic [26:0] diff_neg;
	logic [50:0] th_prod;
	logic [24:0] th_k;
	logic [24:0] rem_full;
	logic [15:0] hu_prod;
	logic [9:0]  hu_c;
	logic [9:0]  r2_full;
	logic [14:0] te_prod;
	logic [31:0] centre;

	// Stall the whole pipe only when the last stage cannot drain
	assign adv      = !stage_vld_q[NUM_STAGES-1] || q_ready;
	assign in_ready = adv;
	assign band_ok  = ({1'b0, band} < BAND_LIMIT);

	// Hold valid bits and the loaded band
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
			cur_band_q  <= BAND_NONE;
		end else if (adv) begin
			stage_vld_q <= {stage_vld_q[NUM_STAGES-2:0], in_valid && band_ok};
			if (in_valid && band_ok) begin
				cur_band_q <= band;
			end
		end
	end

	// Signed distance from band centre after calibration
	assign diff = {2'b00, freq_s1} + {{19{CAL_HZ[tag_s1.band][7]}}, CAL_HZ[tag_s1.band]}
		- {2'b00, CENTRE_HZ[tag_s1.band]};
	assign diff_neg = 27'd0 - diff;

	// Thousands by reciprocal multiply, then remainder below 1000
	assign th_prod  = 51'(dist_s2) * 51'(DIV1K_MUL);
	assign th_k     = 25'(th_s3) * 25'd1000;
	assign rem_full = dist_s3 - th_k;

	// Hundreds and tens from the small remainder
	assign hu_prod = 16'(rem_s4) * 16'd41;
	assign hu_c    = 10'(hu_s5) * 10'd100;
	assign r2_full = rem_s5 - hu_c;
	assign te_prod = 15'(r2_s6) * 15'd205;

	// Advance payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			freq_s1      <= freq_hz;
			tag_s1.chg   <= (band != cur_band_q);
			tag_s1.below <= 1'b0;
			tag_s1.band  <= band;

			tag_s2.chg   <= tag_s1.chg;
			tag_s2.below <= diff[26];
			tag_s2.band  <= tag_s1.band;
			dist_s2      <= diff[26] ? diff_neg[24:0] : diff[24:0];

			tag_s3  <= tag_s2;
			dist_s3 <= dist_s2;
			th_s3   <= th_prod[DIV1K_SHIFT+15:DIV1K_SHIFT];

			tag_s4 <= tag_s3;
			rem_s4 <= rem_full[9:0];
			pk_s4  <= 32'(STEP_K[tag_s3.band]) * 32'(th_s3);

			tag_s5 <= tag_s4;
			rem_s5 <= rem_s4;
			pk_s5  <= pk_s4;
			hu_s5  <= hu_prod[15:12];

			tag_s6 <= tag_s5;
			r2_s6  <= r2_full[6:0];
			ph_s6  <= 32'(STEP_H[tag_s5.band]) * 32'(hu_s5);
			pk_s6  <= pk_s5;

			tag_s7 <= tag_s6;
			te_s7  <= te_prod[14:11];
			ph_s7  <= ph_s6;
			pk_s7  <= pk_s6;

			tag_s8  <= tag_s7;
			pt_s8   <= 32'(STEP_T[tag_s7.band]) * 32'(te_s7);
			suma_s8 <= pk_s7 + ph_s7;

			tag_s9 <= tag_s8;
			sum_s9 <= suma_s8 + pt_s8;
		end
	end

	// Apply offset to the centre word and hand the job over
	assign centre          = CENTRE_WORD[tag_s9.band];
	assign push            = stage_vld_q[NUM_STAGES-1] && q_ready;
	assign push_item.chg   = tag_s9.chg;
	assign push_item.band  = tag_s9.band;
	assign push_item.word  = tag_s9.below ? (centre - sum_s9) : (centre + sum_s9);

endmodule

`default_nettype wire

// ===== rtl/ots_queue.sv =====
// ----------------------------------------------------------------------------
// ots_queue: job queue between front end and back end
// Small register FIFO so the pipeline and the command sequencer stall
// independently.
// ----------------------------------------------------------------------------
`default_nettype none

module ots_queue
	import ots_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  ots_item_t      push_item,
	output logic           ready,
	input  wire logic      pop,
	output logic           valid,
	output ots_item_t      head
);

	ots_item_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign ready = (count_q != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// Store incoming jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("job queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/ots_back.sv =====
// ----------------------------------------------------------------------------
// ots_back: register command sequencer
// Walks each queued job through its command steps and drives the command
// output register, one command per cycle while the receiver takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module ots_back
	import ots_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  ots_item_t  head,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output ots_cmd_t   out_cmd
);

	logic       active_q;
	logic [3:0] step_q;
	logic       out_vld_q;
	ots_cmd_t   cmd_q;
	logic       emit;
	logic [3:0] cur_step;

	// A fresh job starts at the freeze step only on a band change
	assign cur_step  = active_q ? step_q : (head.chg ? ST_FREEZE : ST_TUNE_OPEN);
	assign emit      = q_valid && (!out_vld_q || out_ready);
	assign pop       = emit && (cur_step == ST_TUNE_DONE);
	assign out_valid = out_vld_q;
	assign out_cmd   = cmd_q;

	// Step through the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			step_q    <= ST_FREEZE;
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
			if (cur_step == ST_TUNE_DONE) begin
				active_q <= 1'b0;
			end else begin
				active_q <= 1'b1;
				step_q   <= cur_step + 4'd1;
			end
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (emit) begin
			cmd_q <= ots_command(cur_step, head);
		end
	end

	a_active_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> q_valid)
		else $error("sequencer mid-job with no job at queue head");

	a_last_is_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && cmd_q.last) |-> (cmd_q.op == OP_WR && cmd_q.reg_addr == REG_CTRL
		&& cmd_q.data == CTRL_RUN))
		else $error("final command of a request is not the run write");

endmodule

`default_nettype wire
